// ----- rtl/assert_macros.svh -----
// Assertion macros for RTL that checks its own behaviour.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define CHK_PROP(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never hold outside reset.
`define CHK_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ----- rtl/satl_pkg.sv -----
// Package of types and constants for the set-associative cache tag lookup.
`timescale 1ns / 1ps
package satl_pkg;

  localparam int DEF_SETS      = 512;
  localparam int DEF_WAYS      = 16;
  localparam int DEF_ADDR_BITS = 32;

  localparam int ADDR_W  = 32;
  localparam int TAG_W   = 32;
  localparam int CNT_W   = 32;
  localparam int WAY_O_W = 4;
  localparam int CIDX_W  = 2;
  localparam int CDAT_W  = 32;

  localparam logic [1:0] MODE_FIFO = 2'd0;
  localparam logic [1:0] MODE_LRU  = 2'd1;
  localparam logic [1:0] MODE_RAND = 2'd2;
  localparam logic [1:0] MODE_ALT  = 2'd3;

  localparam logic [CIDX_W-1:0] REG_MODE   = 2'd0;
  localparam logic [CIDX_W-1:0] REG_WAYS   = 2'd1;
  localparam logic [CIDX_W-1:0] REG_OFFSET = 2'd2;
  localparam logic [CIDX_W-1:0] REG_SETB   = 2'd3;

  localparam logic [1:0] RST_MODE   = 2'd1;
  localparam logic [4:0] RST_WAYS   = 5'd4;
  localparam logic [3:0] RST_OFFSET = 4'd5;
  localparam logic [3:0] RST_SETB   = 4'd6;

  localparam int          LFSR_W    = 16;
  localparam logic [15:0] LFSR_SEED = 16'hACE1;
  localparam logic [15:0] LFSR_MASK = 16'hB400;
  localparam int          MOD_STEPS = 4;
  localparam int          MOD_CYC   = LFSR_W / MOD_STEPS;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_MOD,
    ST_FILL
  } state_t;

  typedef struct packed {
    logic clear_wr;
    logic accept;
    logic look;
    logic mod_step;
    logic fill;
    logic write;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic rand_miss;
    logic mod_last;
  } sts_t;

endpackage

// ----- rtl/satl_ctrl.sv -----
// Controller state machine sequencing the clearing pass, lookup and fill.
`timescale 1ns / 1ps
module satl_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  satl_pkg::sts_t  sts,
  output satl_pkg::cmd_t  cmd,
  output logic            busy
);

  satl_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= satl_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state)
      satl_pkg::ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts.clear_last) begin
          state_next = satl_pkg::ST_IDLE;
        end
      end
      satl_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.accept = 1'b1;
          state_next = satl_pkg::ST_LOOK;
        end
      end
      satl_pkg::ST_LOOK: begin
        cmd.look = 1'b1;
        if (sts.rand_miss) begin
          state_next = satl_pkg::ST_MOD;
        end else begin
          cmd.write  = 1'b1;
          state_next = satl_pkg::ST_IDLE;
        end
      end
      satl_pkg::ST_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_last) begin
          state_next = satl_pkg::ST_FILL;
        end
      end
      satl_pkg::ST_FILL: begin
        cmd.fill   = 1'b1;
        cmd.write  = 1'b1;
        state_next = satl_pkg::ST_IDLE;
      end
      default: begin
        state_next = satl_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule

// ----- rtl/satl_dpath.sv -----
// Datapath: configuration, set memories, tag compare, victim choice and counters.
`timescale 1ns / 1ps
module satl_dpath #(
  parameter int SETS      = satl_pkg::DEF_SETS,
  parameter int WAYS      = satl_pkg::DEF_WAYS,
  parameter int ADDR_BITS = satl_pkg::DEF_ADDR_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  satl_pkg::cmd_t                cmd,
  output satl_pkg::sts_t                sts,
  input  logic                          cfg_wr,
  input  logic [satl_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [satl_pkg::CDAT_W-1:0]   cfg_data,
  input  logic [satl_pkg::ADDR_W-1:0]   address,
  output logic                          done,
  output logic                          hit,
  output logic [satl_pkg::WAY_O_W-1:0]  way,
  output logic [satl_pkg::CNT_W-1:0]    access_count,
  output logic [satl_pkg::CNT_W-1:0]    hit_count
);

  localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int N_W    = $clog2(WAYS + 1);
  localparam int MAX_SB = $clog2(SETS + 1) - 1;
  localparam logic [satl_pkg::ADDR_W-1:0] AMASK = (ADDR_BITS >= satl_pkg::ADDR_W) ? '1 :
      satl_pkg::ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);
  localparam int MC_W = (satl_pkg::MOD_CYC > 1) ? $clog2(satl_pkg::MOD_CYC) : 1;

  logic [1:0] mode;
  logic [4:0] ways_cfg;
  logic [3:0] off_cfg;
  logic [3:0] sb_cfg;

  logic [WAYS-1:0][satl_pkg::TAG_W-1:0] tag_mem [SETS];
  logic [WAYS-1:0]                      vld_mem [SETS];
  logic [WAYS-1:0][WAY_W-1:0]           lru_mem [SETS];
  logic [WAY_W-1:0]                     fifo_mem [SETS];

  logic [WAYS-1:0][satl_pkg::TAG_W-1:0] tag_row, tag_row_next;
  logic [WAYS-1:0]                      vld_row, vld_row_next;
  logic [WAYS-1:0][WAY_W-1:0]           lru_row, lru_row_next, lru_init;
  logic [WAY_W-1:0]                     fifo_row, fifo_row_next;

  logic [SET_W-1:0]           set_q, set_in, clr_cnt;
  logic [satl_pkg::TAG_W-1:0] tag_q, tag_in;
  logic [satl_pkg::ADDR_W-1:0] addr_m;
  logic [N_W-1:0]             n;
  logic [3:0]                 sb;
  logic [4:0]                 tag_sh;

  logic             hit_c, vic_found, miss_w;
  logic [WAY_W-1:0] hit_way, vic_way, fifo_way, wr_way, pos;
  logic [N_W-1:0]   p_cur, p_inc;

  logic [satl_pkg::LFSR_W-1:0] lfsr, lfsr_next, mod_val;
  logic [N_W-1:0]              mod_r, mod_r_next;
  logic [N_W:0]                mod_t;
  logic [MC_W-1:0]             mod_cnt;

  logic [satl_pkg::CNT_W-1:0] acc, hits_q, acc_inc, hits_inc;

  always_comb begin
    if (ways_cfg == 5'd0) begin
      n = N_W'(1);
    end else if (32'(ways_cfg) > WAYS) begin
      n = N_W'(WAYS);
    end else begin
      n = N_W'(ways_cfg);
    end
    sb = (32'(sb_cfg) > MAX_SB) ? 4'(MAX_SB) : sb_cfg;
    addr_m = address & AMASK;
    set_in = SET_W'((addr_m >> off_cfg) & ((32'd1 << sb) - 32'd1));
    tag_sh = {1'b0, off_cfg} + {1'b0, sb};
    tag_in = satl_pkg::TAG_W'(addr_m >> tag_sh);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= satl_pkg::RST_MODE;
      ways_cfg <= satl_pkg::RST_WAYS;
      off_cfg  <= satl_pkg::RST_OFFSET;
      sb_cfg   <= satl_pkg::RST_SETB;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        satl_pkg::REG_MODE:   mode     <= cfg_data[1:0];
        satl_pkg::REG_WAYS:   ways_cfg <= cfg_data[4:0];
        satl_pkg::REG_OFFSET: off_cfg  <= cfg_data[3:0];
        satl_pkg::REG_SETB:   sb_cfg   <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < WAYS; k++) begin
      lru_init[k] = WAY_W'(k);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      tag_row  <= tag_mem[set_in];
      vld_row  <= vld_mem[set_in];
      lru_row  <= lru_mem[set_in];
      fifo_row <= fifo_mem[set_in];
      set_q    <= set_in;
      tag_q    <= tag_in;
    end
    if (cmd.clear_wr) begin
      vld_mem[clr_cnt]  <= '0;
      lru_mem[clr_cnt]  <= lru_init;
      fifo_mem[clr_cnt] <= '0;
    end else if (cmd.write) begin
      tag_mem[set_q]  <= tag_row_next;
      vld_mem[set_q]  <= vld_row_next;
      lru_mem[set_q]  <= lru_row_next;
      fifo_mem[set_q] <= fifo_row_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear_wr) begin
      clr_cnt <= clr_cnt + SET_W'(1);
    end
  end

  always_comb begin
    hit_c     = 1'b0;
    hit_way   = '0;
    vic_found = 1'b0;
    vic_way   = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (32'(i) < 32'(n) && vld_row[i] && tag_row[i] == tag_q) begin
        hit_c   = 1'b1;
        hit_way = WAY_W'(i);
      end
      if (!vic_found && N_W'(lru_row[i]) < n) begin
        vic_found = 1'b1;
        vic_way   = lru_row[i];
      end
    end
    p_cur = N_W'(fifo_row);
    if (p_cur >= n) begin
      p_cur = '0;
    end
    fifo_way = WAY_W'(p_cur);
    p_inc = p_cur + N_W'(1);
    if (p_inc >= n) begin
      p_inc = '0;
    end

    if (cmd.fill) begin
      wr_way = WAY_W'(mod_r);
    end else if (hit_c) begin
      wr_way = hit_way;
    end else if (mode == satl_pkg::MODE_FIFO) begin
      wr_way = fifo_way;
    end else begin
      wr_way = vic_way;
    end
    miss_w = !hit_c;

    tag_row_next  = tag_row;
    vld_row_next  = vld_row;
    fifo_row_next = fifo_row;
    if (miss_w) begin
      tag_row_next[wr_way] = tag_q;
      vld_row_next[wr_way] = 1'b1;
    end
    if (miss_w && mode == satl_pkg::MODE_FIFO) begin
      fifo_row_next = WAY_W'(p_inc);
    end

    pos = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (lru_row[i] == wr_way) begin
        pos = WAY_W'(i);
      end
    end
    lru_row_next = lru_row;
    if (mode == satl_pkg::MODE_LRU) begin
      for (int i = 0; i < WAYS - 1; i++) begin
        if (32'(i) >= 32'(pos)) begin
          lru_row_next[i] = lru_row[i + 1];
        end
      end
      lru_row_next[WAYS-1] = wr_way;
    end
  end

  always_comb begin
    lfsr_next = lfsr >> 1;
    if (lfsr[0]) begin
      lfsr_next = lfsr_next ^ satl_pkg::LFSR_MASK;
    end
    mod_r_next = mod_r;
    mod_t      = '0;
    for (int s = 0; s < satl_pkg::MOD_STEPS; s++) begin
      mod_t = {mod_r_next, mod_val[satl_pkg::LFSR_W-1-s]};
      if (mod_t >= {1'b0, n}) begin
        mod_t = mod_t - {1'b0, n};
      end
      mod_r_next = N_W'(mod_t);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr    <= satl_pkg::LFSR_SEED;
      mod_cnt <= '0;
    end else if (cmd.look && sts.rand_miss) begin
      lfsr    <= lfsr_next;
      mod_val <= lfsr_next;
      mod_r   <= '0;
      mod_cnt <= '0;
    end else if (cmd.mod_step) begin
      mod_val <= mod_val << satl_pkg::MOD_STEPS;
      mod_r   <= mod_r_next;
      mod_cnt <= mod_cnt + MC_W'(1);
    end
  end

  always_comb begin
    acc_inc  = (acc == '1) ? acc : acc + satl_pkg::CNT_W'(1);
    hits_inc = (hits_q == '1 || !hit_c) ? hits_q : hits_q + satl_pkg::CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc    <= '0;
      hits_q <= '0;
      done   <= 1'b0;
    end else begin
      done <= cmd.write;
      if (cmd.look) begin
        acc    <= acc_inc;
        hits_q <= hits_inc;
      end
    end
    if (cmd.write) begin
      hit          <= hit_c;
      way          <= satl_pkg::WAY_O_W'(wr_way);
      access_count <= cmd.fill ? acc : acc_inc;
      hit_count    <= cmd.fill ? hits_q : hits_inc;
    end
  end

  assign sts.clear_last = (32'(clr_cnt) == SETS - 1);
  assign sts.rand_miss  = !hit_c &&
      (mode == satl_pkg::MODE_RAND || mode == satl_pkg::MODE_ALT);
  assign sts.mod_last   = (32'(mod_cnt) == satl_pkg::MOD_CYC - 1);

endmodule

// ----- rtl/set_assoc_cache_tag_lookup_core.sv -----
// Accept registers the set row; ST_LOOK compares the tags and writes the result, and a
// pseudo-random miss first runs ST_MOD (the LFSR remainder unit takes four bits a cycle)
// and ST_FILL. A new address is taken only in ST_IDLE; the set memories are read once per
// transaction. Reset: synchronous; afterwards a clearing pass over all sets holds busy
// high. The receiver cannot stall: each result is shown for one cycle under done.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module set_assoc_cache_tag_lookup_core #(
  parameter int SETS      = satl_pkg::DEF_SETS,
  parameter int WAYS      = satl_pkg::DEF_WAYS,
  parameter int ADDR_BITS = satl_pkg::DEF_ADDR_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [satl_pkg::ADDR_W-1:0]   address,
  output logic                          done,
  output logic                          hit,
  output logic [satl_pkg::WAY_O_W-1:0]  way,
  output logic [satl_pkg::CNT_W-1:0]    access_count,
  output logic [satl_pkg::CNT_W-1:0]    hit_count,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [satl_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [satl_pkg::CDAT_W-1:0]   cfg_data
);

  satl_pkg::cmd_t cmd;
  satl_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  satl_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  satl_dpath #(
    .SETS      (SETS),
    .WAYS      (WAYS),
    .ADDR_BITS (ADDR_BITS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_wr       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .address      (address),
    .done         (done),
    .hit          (hit),
    .way          (way),
    .access_count (access_count),
    .hit_count    (hit_count)
  );

  `CHK_PROP(a_done_idle, clk, rst, done |-> !busy, "result strobe while busy")
  `CHK_PROP(a_accept_busy, clk, rst, (start && !busy) |=> busy, "not busy after accept")
  `CHK_PROP(a_done_single, clk, rst, done |=> !done, "two result strobes in a row")
  `CHK_NEVER(a_cmd_excl, clk, rst, cmd.write && cmd.clear_wr, "fill during clearing pass")

endmodule
